// ===== hdl/mnsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnsa_pkg: shared types and constants of the note slot allocator
// Field widths, fixed table geometry, the job record that travels from the
// front end to the back end, and the note-to-lamp mapping.
// ----------------------------------------------------------------------------
package mnsa_pkg;

	localparam int NOTE_ENTRIES = 128;
	localparam int NOTE_AW      = 7;
	localparam int NOTE_W       = 7;
	localparam int NOTE_IN_W    = 8;
	localparam int VEL_W        = 7;
	localparam int DELAY_W      = 8;
	localparam int TEMPO_W      = 8;
	localparam int LAMP_W       = 7;
	localparam int ADDED_W      = 4;
	localparam int LEN_W        = 15;
	localparam int PROD_W       = DELAY_W + TEMPO_W;
	localparam int NC_W         = NOTE_AW + 1;

	localparam int Q_DEPTH      = 2;
	localparam int Q_AW         = 1;

	localparam logic [LEN_W-1:0]   END_LENGTH = 15'd3000;
	localparam logic [LEN_W-1:0]   LENGTH_MAX = 15'd32767;
	localparam logic [LAMP_W-1:0]  ALL_LAMPS  = 7'd127;
	localparam logic [ADDED_W-1:0] ADDED_MAX  = 4'd15;
	localparam logic [TEMPO_W-1:0] TEMPO_RST  = 8'd1;

	localparam logic CMD_NOTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	typedef struct packed {
		logic               is_end;
		logic               tbl_wr;
		logic [NOTE_AW-1:0] tbl_addr;
		logic               note_on;
		logic               render;
		logic [LEN_W-1:0]   length;
	} job_t;

	// note mod 7 for a 7-bit note: reciprocal estimate, then one correction
	function automatic logic [2:0] lamp_index(input logic [NOTE_W-1:0] note);
		logic [13:0] prod;
		logic [4:0]  quo;
		logic [6:0]  rem7;
		logic [3:0]  rem;
		prod = 14'(note) * 14'd73;
		quo  = prod[13:9];
		rem7 = note - (7'(quo) * 7'd7);
		rem  = rem7[3:0];
		if (rem >= 4'd7) begin
			rem = rem - 4'd7;
		end
		return rem[2:0];
	endfunction

endpackage

// ===== hdl/mnsa_event_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnsa_event_if: note event channel
// Valid/ready channel that carries one MIDI event item.
// ----------------------------------------------------------------------------
interface mnsa_event_if import mnsa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic [NOTE_IN_W-1:0] note_num;
	logic [VEL_W-1:0]     velocity;
	logic [DELAY_W-1:0]   delay_units;

	modport source (output valid, cmd, note_num, velocity, delay_units, input ready);
	modport sink   (input valid, cmd, note_num, velocity, delay_units, output ready);
endinterface

// ===== hdl/mnsa_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnsa_result_if: render result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface mnsa_result_if import mnsa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LAMP_W-1:0]  lamp_mask;
	logic [ADDED_W-1:0] added_notes;
	logic [LEN_W-1:0]   evt_len;

	modport source (output valid, lamp_mask, added_notes, evt_len, input ready);
	modport sink   (input valid, lamp_mask, added_notes, evt_len, output ready);
endinterface

// ===== hdl/mnsa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnsa_front: event intake and classification
// Registers an item, scales its delay by the tempo and turns it into a job.
// ----------------------------------------------------------------------------
module mnsa_front import mnsa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	mnsa_event_if.sink         events,
	input  logic [TEMPO_W-1:0] tempo_factor,
	output job_t               push_job,
	output logic               push_valid,
	input  logic               push_ready
);

	logic                 v_s1;
	logic                 cmd_s1;
	logic [NOTE_IN_W-1:0] note_s1;
	logic [VEL_W-1:0]     vel_s1;
	logic [DELAY_W-1:0]   delay_s1;
	logic [PROD_W-1:0]    product;

	assign events.ready = !v_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (events.ready) begin
			v_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			cmd_s1   <= events.cmd;
			note_s1  <= events.note_num;
			vel_s1   <= events.velocity;
			delay_s1 <= events.delay_units;
		end
	end

	assign product = PROD_W'(delay_s1) * PROD_W'(tempo_factor);

	always_comb begin
		push_job.is_end   = (cmd_s1 == CMD_END);
		push_job.tbl_wr   = (note_s1 != '0) && !note_s1[NOTE_IN_W-1];
		push_job.tbl_addr = NOTE_AW'(note_s1 - NOTE_IN_W'(1));
		push_job.note_on  = (vel_s1 != '0);
		push_job.render   = (product != '0);
		if (cmd_s1 == CMD_END) begin
			push_job.length = END_LENGTH;
		end else if (product > PROD_W'(LENGTH_MAX)) begin
			push_job.length = LENGTH_MAX;
		end else begin
			push_job.length = product[LEN_W-1:0];
		end
	end

	assign push_valid = v_s1;

endmodule

// ===== hdl/mnsa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnsa_queue: job queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module mnsa_queue import mnsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t push_job,
	input  logic push_valid,
	output logic push_ready,
	output job_t pop_job,
	output logic pop_valid,
	input  logic pop_ready
);

	job_t            entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (cnt_q != (Q_AW+1)'(Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_job    = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_job;
		end
	end

endmodule

// ===== hdl/mnsa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnsa_back: job execution
// Updates the note table (or clears both stores on an end command), runs the
// free/scan/lamp passes of a render and holds the result in an output register.
// ----------------------------------------------------------------------------
module mnsa_back import mnsa_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  job_t          pop_job,
	input  logic          pop_valid,
	output logic          pop_ready,
	mnsa_result_if.source results
);

	localparam int SCW = $clog2(SLOT_COUNT + 1);
	localparam int SIW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WRITE = 6'b000010,
		ST_FREE  = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_LAMP  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t              state_q;
	job_t                job_q;
	logic [NOTE_W-1:0]   slot_q [SLOT_COUNT];
	logic [SCW-1:0]      sc_q;
	logic [NC_W-1:0]     nc_q;
	logic [LAMP_W-1:0]   lamp_q;
	logic [ADDED_W-1:0]  added_q;

	logic                note_mem [NOTE_ENTRIES];
	logic [NOTE_ENTRIES-1:0] valid_q;
	logic [NOTE_AW-1:0]  rd_addr;
	logic                mem_rd_s1;
	logic                vld_rd_s1;
	logic                sounding_s1;
	logic                v_s1;
	logic [SIW-1:0]      slot_s1;
	logic [NOTE_W-1:0]   note_s1;

	logic [SIW-1:0]      sc_idx;
	logic                held;
	logic                any_free;
	logic [SIW-1:0]      free_idx;
	logic                tbl_write;

	logic                out_v_q;
	logic [LAMP_W-1:0]   out_lamp_q;
	logic [ADDED_W-1:0]  out_added_q;
	logic [LEN_W-1:0]    out_len_q;

	assign pop_ready   = (state_q == ST_IDLE);
	assign sc_idx      = (sc_q < SCW'(SLOT_COUNT)) ? sc_q[SIW-1:0] : '0;
	assign sounding_s1 = mem_rd_s1 && vld_rd_s1;
	assign tbl_write   = (state_q == ST_WRITE) && job_q.tbl_wr;

	always_comb begin
		case (state_q)
			ST_FREE: rd_addr = slot_q[sc_idx] - NOTE_W'(1);
			ST_SCAN: rd_addr = nc_q[NOTE_AW-1:0] - NOTE_AW'(1);
			default: rd_addr = '0;
		endcase
	end

	// held check and lowest free slot against the live slot contents
	always_comb begin
		held     = 1'b0;
		any_free = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (slot_q[i] == note_s1) begin
				held = 1'b1;
			end
			if (slot_q[i] == '0) begin
				any_free = 1'b1;
				free_idx = SIW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_write) begin
			note_mem[job_q.tbl_addr] <= job_q.note_on;
		end
		mem_rd_s1 <= note_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			vld_rd_s1 <= 1'b0;
			v_s1      <= 1'b0;
			slot_s1   <= '0;
			note_s1   <= '0;
			sc_q      <= '0;
			nc_q      <= '0;
			lamp_q    <= '0;
			added_q   <= '0;
			out_v_q   <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_q[i] <= '0;
			end
		end else begin
			vld_rd_s1 <= valid_q[rd_addr];
			v_s1      <= 1'b0;
			if (tbl_write) begin
				valid_q[job_q.tbl_addr] <= 1'b1;
			end
			if (results.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						if (pop_job.is_end) begin
							valid_q <= '0;
							for (int i = 0; i < SLOT_COUNT; i++) begin
								slot_q[i] <= '0;
							end
							lamp_q  <= ALL_LAMPS;
							added_q <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					sc_q    <= '0;
					added_q <= '0;
					state_q <= job_q.render ? ST_FREE : ST_IDLE;
				end
				ST_FREE: begin
					// issue one slot lookup per cycle, drop silent notes in the cycle after
					if (sc_q < SCW'(SLOT_COUNT)) begin
						v_s1    <= 1'b1;
						slot_s1 <= sc_idx;
						sc_q    <= sc_q + 1'b1;
					end else if (!v_s1) begin
						nc_q    <= NC_W'(1);
						state_q <= ST_SCAN;
					end
					if (v_s1 && slot_q[slot_s1] != '0 && !sounding_s1) begin
						slot_q[slot_s1] <= '0;
					end
				end
				ST_SCAN: begin
					if (!nc_q[NC_W-1]) begin
						v_s1    <= 1'b1;
						note_s1 <= nc_q[NOTE_AW-1:0];
						nc_q    <= nc_q + 1'b1;
					end else if (!v_s1) begin
						sc_q    <= '0;
						lamp_q  <= '0;
						state_q <= ST_LAMP;
					end
					if (v_s1 && sounding_s1 && !held && any_free) begin
						slot_q[free_idx] <= note_s1;
						if (added_q != ADDED_MAX) begin
							added_q <= added_q + 1'b1;
						end
					end
				end
				ST_LAMP: begin
					if (sc_q < SCW'(SLOT_COUNT)) begin
						if (slot_q[sc_idx] != '0) begin
							lamp_q <= lamp_q | (LAMP_W'(1) << lamp_index(slot_q[sc_idx]));
						end
						sc_q <= sc_q + 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_v_q || results.ready) begin
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			job_q <= pop_job;
		end
		if (state_q == ST_DONE && (!out_v_q || results.ready)) begin
			out_lamp_q  <= lamp_q;
			out_added_q <= added_q;
			out_len_q   <= job_q.length;
		end
	end

	assign results.valid       = out_v_q;
	assign results.lamp_mask   = out_lamp_q;
	assign results.added_notes = out_added_q;
	assign results.evt_len     = out_len_q;

endmodule

// ===== hdl/midi_note_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_slot_allocator: polyphonic voice allocator for MIDI note events
// Keeps a per-note on/off table and a small set of voice slots, and reports
// a lamp mask, the count of newly placed notes and the event length.
// ----------------------------------------------------------------------------
// Usage: each event item carries a command (note or end of song), a note
// number, a velocity and a delay. A note event with note 1..127 records
// whether that note sounds (nonzero velocity); other note numbers leave the
// table alone. When delay_units times tempo_factor is nonzero, a render runs
// and returns one result item: slots whose note went silent are freed, then
// notes 1..127 are scanned in ascending order and each sounding note without
// a slot takes the lowest free slot (dropped if none is free). The result
// carries added_notes, lamp_mask (bit k set when an occupied slot holds a
// note with note mod 7 equal to k) and evt_len (product saturated at
// 32767). A zero product updates the table and returns nothing. An end
// command empties both stores and returns all lamps lit, zero added and
// length 3000. The front end registers an item and queues it as a job;
// the back end runs a render as a slot pass, a 127-note scan at one table
// read per cycle and a lamp pass, and handles a table-only event or an end
// command without these passes. The single-port note table read is what
// sets the scan length. Two jobs can wait in the queue and a finished
// result sits in an output register, so intake continues while a render
// runs or a result is stalled.
// tempo_factor is written through cfg_wr_en/cfg_wr_data and resets to 1;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module midi_note_slot_allocator import mnsa_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	mnsa_event_if.sink         events,
	mnsa_result_if.source      results,
	input  logic               cfg_wr_en,
	input  logic [TEMPO_W-1:0] cfg_wr_data
);

	logic [TEMPO_W-1:0] tempo_q;
	job_t               push_job;
	logic               push_valid;
	logic               push_ready;
	job_t               pop_job;
	logic               pop_valid;
	logic               pop_ready;

	// hold the tempo register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= TEMPO_RST;
		end else if (cfg_wr_en) begin
			tempo_q <= cfg_wr_data;
		end
	end

	// front end: register the item, scale the delay, classify into a job
	mnsa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.events       (events),
		.tempo_factor (tempo_q),
		.push_job     (push_job),
		.push_valid   (push_valid),
		.push_ready   (push_ready)
	);

	// decouple intake from execution
	mnsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (push_job),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_job    (pop_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// back end: table update, render passes, result register
	mnsa_back #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_job   (pop_job),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.results   (results)
	);

endmodule

// ===== hdl/mnsa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnsa_checker: port-level checks for the note slot allocator
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module mnsa_checker import mnsa_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic [LAMP_W-1:0]  lamp_mask,
	input logic [ADDED_W-1:0] added_notes,
	input logic [LEN_W-1:0]   evt_len
);

	localparam int ADDED_LIMIT = (SLOT_COUNT > 15) ? 15 : SLOT_COUNT;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(lamp_mask)
			&& $stable(added_notes) && $stable(evt_len))
		else $error("stalled result changed or vanished");

	a_added_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> added_notes <= ADDED_W'(ADDED_LIMIT))
		else $error("more notes added than slots exist");

	a_added_lit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && added_notes != '0 |-> lamp_mask != '0)
		else $error("notes placed but no lamp lit");

	a_length_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> evt_len != '0)
		else $error("result with zero event length");

endmodule

bind midi_note_slot_allocator mnsa_checker #(
	.SLOT_COUNT (SLOT_COUNT)
) u_mnsa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (results.valid),
	.res_ready   (results.ready),
	.lamp_mask   (results.lamp_mask),
	.added_notes (results.added_notes),
	.evt_len     (results.evt_len)
);
